// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never hold out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");

`endif

// ----- rtl/dpq_pkg.sv -----
`timescale 1ns / 1ps
package dpq_pkg;

    localparam int SIZE_W = 9;
    localparam int KEY_W  = 15;
    localparam int EPOCH_W = 8;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [0:0] REG_SIZE   = 1'b0;
    localparam logic [0:0] REG_DITHER = 1'b1;

    localparam logic [5:0] BAYER [64] = '{
        6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
        6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
        6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
        6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
        6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
        6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
        6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
        6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
    };

    // step = max(2, 160 / div), indexed by div = size / 8 (0 used as 1)
    localparam logic [7:0] STEP_LUT [33] = '{
        8'd160, 8'd160, 8'd80, 8'd53, 8'd40, 8'd32, 8'd26, 8'd22,
        8'd20,  8'd17,  8'd16, 8'd14, 8'd13, 8'd12, 8'd11, 8'd10,
        8'd10,  8'd9,   8'd8,  8'd8,  8'd8,  8'd7,  8'd7,  8'd6,
        8'd6,   8'd6,   8'd6,  8'd5,  8'd5,  8'd5,  8'd5,  8'd5,
        8'd5
    };

    typedef struct packed {
        logic             op;
        logic [7:0]       entry_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic clearing;
        logic load;
    } t_back_stat;

    function automatic logic [7:0] clamp_add(input logic [7:0] c,
                                             input logic signed [9:0] nudge);
        logic signed [9:0] s;
        s = $signed({2'b00, c}) + nudge;
        if (s < 0) begin
            clamp_add = 8'd0;
        end else if (s > 10'sd255) begin
            clamp_add = 8'd255;
        end else begin
            clamp_add = s[7:0];
        end
    endfunction

endpackage

// ----- rtl/dpq_if.sv -----
`timescale 1ns / 1ps
interface dpq_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] entry_index;
    logic [2:0] x_phase;
    logic [2:0] y_phase;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, op, entry_index, x_phase, y_phase, red, green, blue,
                    input ready);
    modport sink (input valid, op, entry_index, x_phase, y_phase, red, green, blue,
                  output ready);
endinterface

interface dpq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] color_index;

    modport source (output valid, color_index, input ready);
    modport sink (input valid, color_index, output ready);
endinterface

// ----- rtl/dpq_ram.sv -----
`timescale 1ns / 1ps
module dpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/dpq_fifo.sv -----
`timescale 1ns / 1ps
module dpq_fifo import dpq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    input  logic i_pop,
    output t_req o_head,
    output logic o_full,
    output logic o_empty
);
    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule

// ----- rtl/dpq_front.sv -----
`timescale 1ns / 1ps
module dpq_front import dpq_pkg::*; (
    dpq_in_if.sink            i_in,
    input  logic [SIZE_W-1:0] i_n,
    input  logic              i_dither,
    input  logic              i_full,
    input  logic              i_clearing,
    output logic              o_push,
    output t_req              o_req
);
    logic [5:0]         div;
    logic [7:0]         step;
    logic [5:0]         bay;
    logic signed [6:0]  bm;
    logic signed [15:0] prod;
    logic signed [15:0] mag;
    logic signed [15:0] nudge;
    logic signed [9:0]  nudge10;
    logic [7:0]         cr, cg, cb;

    assign i_in.ready = !i_full && !i_clearing;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        div = i_n[8:3];
        if (div == 6'd0) begin
            div = 6'd1;
        end
        step  = STEP_LUT[div];
        bay   = BAYER[{i_in.y_phase, i_in.x_phase}];
        bm    = $signed({1'b0, bay}) - 7'sd32;
        prod  = 16'(bm) * $signed({8'b0, step});
        mag   = (prod < 0) ? -prod : prod;
        // divide by 64 with truncation toward zero
        nudge = (prod < 0) ? -(mag >>> 6) : (mag >>> 6);
        nudge10 = i_dither ? 10'(nudge) : 10'sd0;
        cr = clamp_add(i_in.red, nudge10);
        cg = clamp_add(i_in.green, nudge10);
        cb = clamp_add(i_in.blue, nudge10);

        o_req.op          = i_in.op;
        o_req.entry_index = i_in.entry_index;
        if (i_in.op == OP_WRITE) begin
            o_req.red   = i_in.red;
            o_req.green = i_in.green;
            o_req.blue  = i_in.blue;
        end else begin
            o_req.red   = cr;
            o_req.green = cg;
            o_req.blue  = cb;
        end
        o_req.key = {cr[7:3], cg[7:3], cb[7:3]};
    end
endmodule

// ----- rtl/dpq_back.sv -----
`timescale 1ns / 1ps
module dpq_back import dpq_pkg::*; #(
    parameter int PALETTE_DEPTH = 256,
    parameter int CACHE_DEPTH   = 32768
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_head,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic [SIZE_W-1:0] i_n,
    input  logic              i_bump,
    dpq_out_if.source         o_out,
    output t_back_stat        o_stat
);
    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(CACHE_DEPTH);
    localparam int DW = EPOCH_W + 8;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_SRCH = 3'd3;

    logic [2:0]         r_st;
    logic [CW-1:0]      r_clr;
    logic [EPOCH_W-1:0] r_epoch;
    logic [CW-1:0]      r_key;
    logic [7:0]         r_r, r_g, r_b;
    logic [SIZE_W-1:0]  r_n;
    logic [SIZE_W-1:0]  r_cnt;
    logic               r_p1_v, r_p2_v;
    logic [7:0]         r_p1_idx, r_p2_idx;
    logic [16:0]        r_sq_r, r_sq_g, r_sq_b;
    logic [19:0]        r_best_d;
    logic [7:0]         r_best;
    logic               r_out_v;
    logic [7:0]         r_out_idx;

    logic               pal_we;
    logic [23:0]        pal_rd;
    logic               c_we;
    logic [CW-1:0]      c_waddr;
    logic [DW-1:0]      c_wdata;
    logic [DW-1:0]      c_rd;
    logic               wr_ok;
    logic               pal_bump;
    logic               bump;
    logic               done;
    logic               load;
    logic signed [8:0]  dr, dg, db;
    logic signed [17:0] pr, pg, pb;
    logic [19:0]        d_sum;

    assign o_pop    = (r_st == ST_IDLE) && !i_empty && !r_out_v;
    assign wr_ok    = ({1'b0, i_head.entry_index} < SIZE_W'(PALETTE_DEPTH));
    assign pal_we   = o_pop && (i_head.op == OP_WRITE) && wr_ok;
    assign pal_bump = pal_we;
    assign bump     = pal_bump || i_bump;
    assign done     = (r_st == ST_SRCH) && (r_cnt == r_n) && !r_p1_v && !r_p2_v;
    assign load     = done || ((r_st == ST_LOOK) && (c_rd[DW-1:8] == r_epoch));

    dpq_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_head.entry_index[AW-1:0]),
        .i_wdata ({i_head.red, i_head.green, i_head.blue}),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (pal_rd)
    );

    always_comb begin
        c_we    = 1'b0;
        c_waddr = r_key;
        c_wdata = {r_epoch, r_best};
        if (r_st == ST_CLR) begin
            c_we    = 1'b1;
            c_waddr = r_clr;
            c_wdata = '0;
        end else if (done) begin
            c_we = 1'b1;
        end
    end

    dpq_ram #(.WIDTH(DW), .DEPTH(CACHE_DEPTH)) u_cache (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (i_head.key[CW-1:0]),
        .o_rdata (c_rd)
    );

    always_comb begin
        dr    = $signed({1'b0, r_r}) - $signed({1'b0, pal_rd[23:16]});
        dg    = $signed({1'b0, r_g}) - $signed({1'b0, pal_rd[15:8]});
        db    = $signed({1'b0, r_b}) - $signed({1'b0, pal_rd[7:0]});
        pr    = dr * dr;
        pg    = dg * dg;
        pb    = db * db;
        d_sum = 20'({r_sq_r, 1'b0}) + 20'({r_sq_g, 2'b00}) + 20'(r_sq_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_CLR;
            r_clr   <= '0;
            r_epoch <= EPOCH_W'(1);
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_v <= 1'b0;
            end
            if (load) begin
                r_out_v <= 1'b1;
            end

            unique case (r_st)
                ST_CLR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == CW'(CACHE_DEPTH - 1)) begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (o_pop && (i_head.op == OP_PIXEL)) begin
                        r_st <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    r_st <= load ? ST_IDLE : ST_SRCH;
                end
                ST_SRCH: begin
                    if (done) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase

            r_p1_v <= (r_st == ST_SRCH) && (r_cnt < r_n);
            r_p2_v <= r_p1_v;

            // epoch 0 marks a cleared entry; wrap needs a full clearing pass
            if (bump) begin
                if (r_epoch == '1) begin
                    r_epoch <= EPOCH_W'(1);
                    r_st    <= ST_CLR;
                    r_clr   <= '0;
                end else begin
                    r_epoch <= r_epoch + EPOCH_W'(1);
                end
            end
        end

        if (o_pop) begin
            r_key <= i_head.key[CW-1:0];
            r_r   <= i_head.red;
            r_g   <= i_head.green;
            r_b   <= i_head.blue;
            r_n   <= i_n;
        end
        if (r_st == ST_LOOK) begin
            r_cnt    <= '0;
            r_best_d <= '1;
            r_best   <= 8'd0;
        end else if ((r_st == ST_SRCH) && (r_cnt < r_n)) begin
            r_cnt <= r_cnt + SIZE_W'(1);
        end
        r_p1_idx <= r_cnt[7:0];
        r_p2_idx <= r_p1_idx;
        r_sq_r   <= pr[16:0];
        r_sq_g   <= pg[16:0];
        r_sq_b   <= pb[16:0];
        if ((r_st == ST_SRCH) && r_p2_v && (d_sum < r_best_d)) begin
            r_best_d <= d_sum;
            r_best   <= r_p2_idx;
        end
        if (load) begin
            r_out_idx <= done ? r_best : c_rd[7:0];
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.color_index = r_out_idx;
    assign o_stat.clearing   = (r_st == ST_CLR);
    assign o_stat.load       = load;
endmodule

// ----- rtl/dithered_palette_quantiser.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// channel   dir  handshake        payload
// i_in      in   valid/ready      op, entry_index, x_phase, y_phase, red, green, blue
// o_out     out  valid/ready      color_index
// i_cfg_*   in   write enable     idx 0 palette_size, idx 1 dither_enable
//
// Cache hit: a pixel request passes a cache RAM read, a tag check and a result
// handoff; the back end takes the next request once the result is accepted.
// Miss: a search over the effective palette size, one palette RAM read per cycle
// feeding a two-stage distance pipeline.
// Palette write: handled in the back end's idle state.
// After reset, and whenever the 8-bit cache epoch wraps, a clearing pass of
// all CACHE_DEPTH cache entries runs; no request is taken meanwhile.
// A two-entry queue lets the front take requests while the back stalls.
module dithered_palette_quantiser import dpq_pkg::*; #(
    parameter int PALETTE_DEPTH = 256,
    parameter int CACHE_DEPTH   = 32768
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dpq_in_if.sink            i_in,
    dpq_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_data
);
    logic [SIZE_W-1:0] r_size;
    logic              r_dither;
    logic [SIZE_W-1:0] n_eff;
    logic              cfg_bump;
    logic              push, pop, full, empty;
    t_req              req, head;
    t_back_stat        stat;

    // size write invalidates the cache only when the value changes
    assign cfg_bump = i_cfg_we && (i_cfg_idx == REG_SIZE) && (i_cfg_data != r_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SIZE_W'(256);
            r_dither <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIZE:   r_size   <= i_cfg_data;
                REG_DITHER: r_dither <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // effective size: 0 acts as 1, capped at the palette depth
    always_comb begin
        n_eff = r_size;
        if (r_size == '0) begin
            n_eff = SIZE_W'(1);
        end else if (r_size > SIZE_W'(PALETTE_DEPTH)) begin
            n_eff = SIZE_W'(PALETTE_DEPTH);
        end
    end

    dpq_front u_front (
        .i_in       (i_in),
        .i_n        (n_eff),
        .i_dither   (r_dither),
        .i_full     (full),
        .i_clearing (stat.clearing),
        .o_push     (push),
        .o_req      (req)
    );

    dpq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (req),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    dpq_back #(.PALETTE_DEPTH(PALETTE_DEPTH), .CACHE_DEPTH(CACHE_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .i_n     (n_eff),
        .i_bump  (cfg_bump),
        .o_out   (o_out),
        .o_stat  (stat)
    );

    // a result is loaded only into an empty output register
    `ASSERT_NEVER(a_load_over, i_clk, i_rst_n, stat.load && o_out.valid)
    // no request enters during a clearing pass
    `ASSERT_CLK(a_clr_block, i_clk, i_rst_n, stat.clearing |-> !push)
endmodule
